/* hw/rtl/lubr_pkg.sv */
// Package for the longest unique byte run block.
// Holds shared constants, the stage control struct and the symbol fold function.
// No dependencies.
`timescale 1ns / 1ps

package lubr_pkg;

	// Default configuration
	localparam int unsigned ALPHABET_SIZE_DEF = 256;
	localparam int unsigned POSITION_BITS_DEF = 16;

	// Result length field
	localparam int unsigned OUT_LEN_BITS = 16;
	localparam logic [OUT_LEN_BITS-1:0] OUT_LEN_MAX = '1;

	// Control from the input stage to the window tracker
	typedef struct packed {
		logic advance;   // stage-1 transaction retires this cycle
		logic has_byte;
		logic is_last;
	} win_ctl_t;

	// Fold a byte into the alphabet: b mod a, by eight restoring subtract steps
	function automatic logic [7:0] fold_byte(input logic [7:0] b, input int unsigned a);
		int unsigned v;
		int unsigned step;
		v = 32'(b);
		for (int k = 7; k >= 0; k--) begin
			step = a << k;
			if (v >= step) begin
				v = v - step;
			end
		end
		return v[7:0];
	endfunction

endpackage

/* hw/rtl/lubr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lubr_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port (returns old data on a same-address write)
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hw/rtl/lubr_window.sv */
// Window tracker: seen marks, position counter, window start, best length.
// Takes one byte per cycle while the input stage advances, and issues the last-position table write.
// Depends on lubr_pkg.
`timescale 1ns / 1ps

module lubr_window #(
	parameter int unsigned ALPHABET_SIZE = lubr_pkg::ALPHABET_SIZE_DEF,
	parameter int unsigned POSITION_BITS = lubr_pkg::POSITION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lubr_pkg::win_ctl_t               ctl,
	input  logic [$clog2(ALPHABET_SIZE)-1:0] sym,
	input  logic [POSITION_BITS-1:0]         prev_pos,
	output logic                             wr_en,
	output logic [$clog2(ALPHABET_SIZE)-1:0] wr_addr,
	output logic [POSITION_BITS-1:0]         wr_data,
	output logic [lubr_pkg::OUT_LEN_BITS-1:0] res_len,
	output logic                             res_sat
);

	import lubr_pkg::*;

	localparam int unsigned CMP_W = (POSITION_BITS > OUT_LEN_BITS) ? POSITION_BITS : OUT_LEN_BITS;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic [ALPHABET_SIZE-1:0] seen_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] start_q;
	logic [POSITION_BITS-1:0] best_q;
	logic                     ovf_q;

	logic                     pos_full;
	logic                     take;
	logic                     repeat_hit;
	logic [POSITION_BITS-1:0] start_n;
	logic [POSITION_BITS-1:0] run_len;
	logic [POSITION_BITS-1:0] best_n;
	logic                     ovf_n;
	logic [CMP_W-1:0]         best_ext;
	logic                     too_long;

	// Per-byte window update
	always_comb begin
		pos_full   = (pos_q == POS_MAX);
		take       = ctl.has_byte && !pos_full;
		repeat_hit = seen_q[sym] && (prev_pos >= start_q);
		start_n    = repeat_hit ? (prev_pos + 1'b1) : start_q;
		run_len    = pos_q - start_n + 1'b1;
		best_n     = best_q;
		if (take && (run_len > best_q)) begin
			best_n = run_len;
		end
		ovf_n = ovf_q || (ctl.has_byte && pos_full);
	end

	// Result with clamp to the output width
	always_comb begin
		best_ext = CMP_W'(best_n);
		too_long = best_ext > CMP_W'(OUT_LEN_MAX);
		res_len  = too_long ? OUT_LEN_MAX : best_ext[OUT_LEN_BITS-1:0];
		res_sat  = ovf_n || too_long;
	end

	// Last-position table write
	assign wr_en   = ctl.advance && take;
	assign wr_addr = sym;
	assign wr_data = pos_q;

	// Per-string state; cleared at the end of each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			pos_q   <= '0;
			start_q <= '0;
			best_q  <= '0;
			ovf_q   <= 1'b0;
		end else if (ctl.advance) begin
			if (ctl.is_last) begin
				seen_q  <= '0;
				pos_q   <= '0;
				start_q <= '0;
				best_q  <= '0;
				ovf_q   <= 1'b0;
			end else begin
				ovf_q  <= ovf_n;
				best_q <= best_n;
				if (take) begin
					seen_q[sym] <= 1'b1;
					pos_q       <= pos_q + 1'b1;
					start_q     <= start_n;
				end
			end
		end
	end

endmodule

/* hw/rtl/longest_unique_byte_run.sv */
// Top level of the longest unique byte run block.
// Input stage, last-position RAM with bypass, window tracker, result register.
// Depends on lubr_pkg, lubr_ram, lubr_window.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-----------------------------------
//   item    | item_valid / item_stall    | byte_value, has_byte, is_last
//   result  | result_valid / result_stall| longest_length, length_saturated
//
// One byte per cycle while the item channel is not stalled: accepted bytes are held in
// the input stage, where the last-position RAM read (issued at accept) returns; a result
// passes from the input stage into the result register. The RAM read-to-write loop is closed by a bypass.
// Reset clears all control and per-string state; the RAM needs no clearing pass.
// Only a last item waiting behind a held result stalls the item channel.
`timescale 1ns / 1ps

module longest_unique_byte_run #(
	parameter int unsigned ALPHABET_SIZE = lubr_pkg::ALPHABET_SIZE_DEF,
	parameter int unsigned POSITION_BITS = lubr_pkg::POSITION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [7:0]                        byte_value,
	input  logic                              has_byte,
	input  logic                              is_last,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [lubr_pkg::OUT_LEN_BITS-1:0] longest_length,
	output logic                              length_saturated
);

	import lubr_pkg::*;

	localparam int unsigned SYM_BITS = $clog2(ALPHABET_SIZE);

	logic                     valid_s1;
	logic                     has_byte_s1;
	logic                     is_last_s1;
	logic [SYM_BITS-1:0]      sym_s1;
	logic                     byp_hit_s1;
	logic [POSITION_BITS-1:0] byp_pos_s1;

	logic                     accept;
	logic                     advance;
	logic [SYM_BITS-1:0]      sym_in;
	logic [POSITION_BITS-1:0] rd_pos;
	logic [POSITION_BITS-1:0] prev_pos;
	win_ctl_t                 ctl;
	logic                     wr_en;
	logic [SYM_BITS-1:0]      wr_addr;
	logic [POSITION_BITS-1:0] wr_data;
	logic [OUT_LEN_BITS-1:0]  res_len;
	logic                     res_sat;
	logic [OUT_LEN_BITS-1:0]  len_q;
	logic                     sat_q;
	logic                     out_valid_q;

	// Handshake: stage 1 retires unless a result is blocked behind a held one
	assign advance    = valid_s1 && (!is_last_s1 || !out_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign sym_in     = SYM_BITS'(fold_byte(byte_value, ALPHABET_SIZE));

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload and bypass of a same-edge table write
	always_ff @(posedge clk) begin
		if (accept) begin
			has_byte_s1 <= has_byte;
			is_last_s1  <= is_last;
			sym_s1      <= sym_in;
			byp_hit_s1  <= wr_en && (wr_addr == sym_in);
			byp_pos_s1  <= wr_data;
		end
	end

	// Last-position table
	lubr_ram #(
		.WIDTH (POSITION_BITS),
		.DEPTH (ALPHABET_SIZE)
	) u_last_pos (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (accept),
		.rd_addr (sym_in),
		.rd_data (rd_pos)
	);

	assign prev_pos = byp_hit_s1 ? byp_pos_s1 : rd_pos;

	assign ctl.advance  = advance;
	assign ctl.has_byte = has_byte_s1;
	assign ctl.is_last  = is_last_s1;

	lubr_window #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.POSITION_BITS (POSITION_BITS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sym      (sym_s1),
		.prev_pos (prev_pos),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.res_len  (res_len),
		.res_sat  (res_sat)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_last_s1) begin
			len_q <= res_len;
			sat_q <= res_sat;
		end
	end

	assign result_valid     = out_valid_q;
	assign longest_length   = len_q;
	assign length_saturated = sat_q;

endmodule

/* hw/rtl/lubr_checker.sv */
// Port-level checks for the longest unique byte run block, bound to the top level.
// Depends on longest_unique_byte_run.
`timescale 1ns / 1ps

module lubr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        is_last,
	input logic        result_valid,
	input logic        result_stall,
	input logic [15:0] longest_length,
	input logic        length_saturated
);

	// A held result keeps its value
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(longest_length)
			&& $stable(length_saturated))
		else $error("result changed while stalled");

	// Items are only held back by a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item stall without result backpressure");

	// A last item accepted while the result register is empty shows after the input stage and the result register
	a_last_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && is_last && !result_valid |=> ##1 result_valid)
		else $error("result missing after last transaction");

	// Idle result side leaves the item channel free
	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
		else $error("item stall with empty result register");

endmodule

bind longest_unique_byte_run lubr_checker u_lubr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item_valid),
	.item_stall       (item_stall),
	.is_last          (is_last),
	.result_valid     (result_valid),
	.result_stall     (result_stall),
	.longest_length   (longest_length),
	.length_saturated (length_saturated)
);

/* verif/longest_unique_byte_run_tb.sv */
// Testbench for longest_unique_byte_run: directed strings, then random strings with idling on
// both channels, then a closing run without idling, checked against a predictor or typed lengths.
// Depends on lubr_pkg and longest_unique_byte_run.
`timescale 1ns / 1ps

module longest_unique_byte_run_tb;

	localparam int unsigned ALPHA     = lubr_pkg::ALPHABET_SIZE_DEF;
	localparam int unsigned POS_BITS  = lubr_pkg::POSITION_BITS_DEF;
	localparam int unsigned POS_FULL  = (32'd1 << POS_BITS) - 1;
	localparam int unsigned CLK_HALF  = 2;
	localparam int unsigned N_DIR     = 25;
	localparam int unsigned RND_ITEMS = 1750;
	// Bound above the slowest legal run (full idle bursts and stalls on every transaction)
	localparam int unsigned CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic [lubr_pkg::OUT_LEN_BITS-1:0] len;
		logic                              sat;
	} run_result_t;

	typedef struct packed {
		logic [7:0]                        bval;
		logic                              hb;
		logic                              eos;
		bit                                typed;
		logic [lubr_pkg::OUT_LEN_BITS-1:0] len;
		logic                              sat;
	} stim_row_t;

	logic                              clk          = 1'b0;
	logic                              arst_n       = 1'b0;
	logic                              item_valid   = 1'b0;
	logic                              item_stall;
	logic [7:0]                        byte_value   = 8'h00;
	logic                              has_byte     = 1'b0;
	logic                              is_last      = 1'b0;
	logic                              result_valid;
	logic                              result_stall = 1'b0;
	logic [lubr_pkg::OUT_LEN_BITS-1:0] longest_length;
	logic                              length_saturated;

	// Predictor state: last position per symbol, seen marks, window
	int unsigned pos_of [ALPHA];
	bit          seen_of [ALPHA];
	int unsigned pos_cnt;
	int unsigned win_lo;
	int unsigned best_len;
	bit          pos_ovf;

	run_result_t pending_runs [$];
	stim_row_t   dir_rows [N_DIR];

	int unsigned cycle_cnt     = 0;
	int unsigned err_cnt       = 0;
	int unsigned runs_checked  = 0;
	int unsigned strings_done  = 0;
	int unsigned empty_strings = 0;
	int unsigned sat_strings   = 0;
	int unsigned bytes_sent    = 0;
	int unsigned tx_rate       = 0;	// sender idle chance, out of 16
	int unsigned rx_rate       = 0;	// receiver stall chance, out of 16

	longest_unique_byte_run i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.byte_value       (byte_value),
		.has_byte         (has_byte),
		.is_last          (is_last),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.longest_length   (longest_length),
		.length_saturated (length_saturated)
	);

	always #(CLK_HALF) clk = ~clk;

	// Per-string state goes back to zero after every string end
	function automatic void clear_run_state();
		foreach (seen_of[i]) seen_of[i] = 1'b0;
		pos_cnt  = 0;
		win_lo   = 0;
		best_len = 0;
		pos_ovf  = 1'b0;
	endfunction

	// Advance the window by one transaction; returns 1 when a length is due
	function automatic bit track_item(input logic [7:0] bval, input logic hb, input logic eos,
			output run_result_t res);
		int unsigned sym;
		int unsigned here;
		int unsigned span;
		res = '0;
		if (hb) begin
			sym  = int'(bval) % ALPHA;
			here = pos_cnt;
			if (here >= POS_FULL) begin
				pos_ovf = 1'b1;
			end else begin
				// repeat inside the window: start moves past its earlier position
				if (seen_of[sym] && pos_of[sym] >= win_lo) begin
					win_lo = pos_of[sym] + 1;
				end
				pos_of[sym]  = here;
				seen_of[sym] = 1'b1;
				span = here - win_lo + 1;
				if (span > best_len) begin
					best_len = span;
				end
				pos_cnt = here + 1;
			end
		end
		if (!eos) begin
			return 1'b0;
		end
		if (best_len > int'(lubr_pkg::OUT_LEN_MAX)) begin
			res.len = lubr_pkg::OUT_LEN_MAX;
			res.sat = 1'b1;
		end else begin
			res.len = best_len[lubr_pkg::OUT_LEN_BITS-1:0];
			res.sat = pos_ovf;
		end
		strings_done++;
		if (pos_cnt == 0 && !pos_ovf) empty_strings++;
		if (res.sat) sat_strings++;
		clear_run_state();
		return 1'b1;
	endfunction

	// Present one transaction, wait for acceptance, then record what it should produce
	task automatic push_item(input logic [7:0] bval, input logic hb, input logic eos,
			input bit has_typed = 1'b0, input run_result_t typed = '0);
		run_result_t res;
		if (tx_rate != 0 && $urandom_range(0, 15) < tx_rate) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_valid <= 1'b1;
		byte_value <= bval;
		has_byte   <= hb;
		is_last    <= eos;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (hb) bytes_sent++;
		if (track_item(bval, hb, eos, res)) begin
			pending_runs.push_back(has_typed ? typed : res);
		end
	endtask

	// Drop valid and hold off until every pending length has come back
	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_runs.size() != 0) @(posedge clk);
	endtask

	// One random string; returns the number of counted transactions
	task automatic random_string(output int unsigned n_items);
		int unsigned kind;
		int unsigned len;
		int unsigned span;
		int unsigned back;
		logic [7:0]  base;
		logic [7:0]  stride;
		logic [7:0]  bval;
		bit          tail_empty;
		n_items    = 0;
		kind       = $urandom_range(0, 19);
		base       = 8'($urandom_range(0, 255));
		stride     = 8'($urandom_range(0, 127) * 2 + 1);
		span       = $urandom_range(1, 12);
		len        = (kind == 1) ? $urandom_range(200, 320) : $urandom_range(1, 40);
		tail_empty = ($urandom_range(0, 7) == 0);
		// empty string
		if (kind == 0) begin
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			n_items = 1;
			return;
		end
		for (int i = 0; i < len; i++) begin
			if (kind >= 2 && kind <= 7) begin
				// narrow alphabet: many repeats
				bval = base + 8'($urandom_range(0, span));
			end else if (kind >= 8 && kind <= 12) begin
				bval = 8'($urandom_range(0, 255));
			end else begin
				// mostly distinct sequence, with a repeat of a recent byte now and then
				back = 0;
				if (i > 0 && $urandom_range(0, 9) == 0) begin
					back = $urandom_range(1, (i < 8) ? i : 8);
				end
				bval = base + 8'(i - back) * stride;
			end
			// ignored transaction: no byte, not the end
			if ($urandom_range(0, 15) == 0) begin
				push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			push_item(bval, 1'b1, (i == len - 1) && !tail_empty);
			n_items++;
		end
		if (tail_empty) begin
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			n_items++;
		end
	endtask

	// Receiver stall bursts
	always @(posedge clk) begin
		int unsigned stall_left;
		logic        nxt;
		nxt = 1'b0;
		if (stall_left != 0) begin
			stall_left--;
			nxt = 1'b1;
		end else if (rx_rate != 0 && $urandom_range(0, 15) < rx_rate) begin
			stall_left = $urandom_range(0, 14);
			nxt = 1'b1;
		end
		result_stall <= nxt;
	end

	// Compare each accepted result with the oldest pending length
	always @(posedge clk) begin
		run_result_t want;
		cycle_cnt++;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_runs.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10) begin
					$display("unexpected result: len=%0d sat=%0d at cycle %0d",
						longest_length, length_saturated, cycle_cnt);
				end
			end else begin
				want = pending_runs.pop_front();
				runs_checked++;
				if (longest_length !== want.len || length_saturated !== want.sat) begin
					err_cnt++;
					if (err_cnt <= 10) begin
						$display("mismatch on string %0d: len exp %0d got %0d, sat exp %0d got %0d",
							runs_checked, want.len, longest_length, want.sat, length_saturated);
					end
				end
			end
		end
	end

	// Timeout
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d lengths outstanding", cycle_cnt,
			pending_runs.size());
		$display("longest_unique_byte_run_tb: done, errors");
		$finish;
	end

	initial begin
		int unsigned rnd_count;
		int unsigned n;
		bit          paused;
		// bval, hb, eos, typed, len, sat
		dir_rows = '{
			'{8'h00, 1'b0, 1'b1, 1'b1, 16'd0, 1'b0},	// empty string right after reset
			'{8'hFF, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0},	// ignored
			'{8'h00, 1'b1, 1'b1, 1'b1, 16'd1, 1'b0},
			'{8'hFF, 1'b1, 1'b1, 1'b1, 16'd1, 1'b0},
			'{8'h41, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},	// back-to-back repeat
			'{8'h41, 1'b1, 1'b1, 1'b1, 16'd1, 1'b0},
			'{8'h61, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},	// abcabcbb
			'{8'h62, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
			'{8'h63, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
			'{8'h61, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
			'{8'h62, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
			'{8'h63, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
			'{8'h62, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
			'{8'h62, 1'b1, 1'b1, 1'b1, 16'd3, 1'b0},
			'{8'h61, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},	// abba: old a is left of the window
			'{8'h62, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
			'{8'h62, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
			'{8'h61, 1'b1, 1'b1, 1'b1, 16'd2, 1'b0},
			'{8'h00, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},	// string closed by a byteless end
			'{8'hFF, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
			'{8'h5A, 1'b0, 1'b1, 1'b1, 16'd2, 1'b0},
			'{8'h55, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
			'{8'h55, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0},	// ignored mid-string
			'{8'hAA, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0},
			'{8'h55, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0}
		};
		foreach (pos_of[i]) pos_of[i] = 0;
		clear_run_state();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings
		tx_rate = 4;
		rx_rate = 4;
		for (int r = 0; r < N_DIR; r++) begin
			push_item(dir_rows[r].bval, dir_rows[r].hb, dir_rows[r].eos, dir_rows[r].typed,
				{dir_rows[r].len, dir_rows[r].sat});
		end

		// Random strings, with one full pause of the sender half way
		rnd_count = 0;
		paused    = 1'b0;
		while (rnd_count < RND_ITEMS) begin
			tx_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			rx_rate = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			random_string(n);
			rnd_count += n;
			if (!paused && rnd_count >= RND_ITEMS / 2) begin
				drain_results();
				paused = 1'b1;
			end
		end

		// Closing part without idling: let any stall burst run out, then strings back to back
		tx_rate = 0;
		rx_rate = 0;
		drain_results();
		repeat (16) @(posedge clk);
		for (int s = 0; s < 4; s++) begin
			random_string(n);
		end
		// short string right after the others must start clean
		push_item(8'h10, 1'b1, 1'b0);
		push_item(8'h20, 1'b1, 1'b1, 1'b1, {16'd2, 1'b0});

		drain_results();
		repeat (10) @(posedge clk);
		$display("covered %0d strings (%0d empty, %0d saturated), %0d bytes",
			strings_done, empty_strings, sat_strings, bytes_sent);
		$display("%0d lengths compared, %0d errors, %0d cycles", runs_checked, err_cnt, cycle_cnt);
		if (err_cnt == 0 && pending_runs.size() == 0) begin
			$display("longest_unique_byte_run_tb: done, clean");
		end else begin
			$display("longest_unique_byte_run_tb: done, errors");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/lubr_pkg.sv
hw/rtl/lubr_ram.sv
hw/rtl/lubr_window.sv
hw/rtl/longest_unique_byte_run.sv
hw/rtl/lubr_checker.sv
verif/longest_unique_byte_run_tb.sv
